FILE: rtl/core/mbrtu_pkg.sv
// ============================================================================
// mbrtu_pkg - shared types and constants of the Modbus RTU slave frame handler
// Frame byte positions, status codes, reply request struct and the
// byte-wide CRC-16 (Modbus) update.
// ============================================================================
package mbrtu_pkg;

    // Result status carried with every output transaction
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_CRC   = 2'd1,
        ST_ADDR  = 2'd2,
        ST_SHORT = 2'd3
    } frame_status_t;

    // Byte positions within request and reply frames
    localparam logic [2:0] BYTE_ID      = 3'd0;
    localparam logic [2:0] BYTE_FUNC    = 3'd1;
    localparam logic [2:0] BYTE_ADDR_HI = 3'd2;
    localparam logic [2:0] BYTE_ADDR_LO = 3'd3;
    localparam logic [2:0] BYTE_VAL_HI  = 3'd4;
    localparam logic [2:0] BYTE_VAL_LO  = 3'd5;
    localparam logic [2:0] BYTE_CRC_HI  = 3'd6;
    localparam logic [2:0] BYTE_CRC_LO  = 3'd7;

    // CRC-16 Modbus
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Function and exception codes
    localparam logic [7:0]  FUNC_READ = 8'h03;
    localparam logic [7:0]  EXC_FLAG  = 8'h80;
    localparam logic [15:0] EXC_FUNC  = 16'h0001;
    localparam logic [15:0] EXC_ADDR  = 16'h0002;

    // Configuration registers
    localparam logic        CFG_IDX_NODE_ID  = 1'b0;
    localparam logic        CFG_IDX_REG_ADDR = 1'b1;
    localparam logic [7:0]  NODE_ID_RST      = 8'h02;
    localparam logic [15:0] REG_ADDR_RST     = 16'h0006;

    // Reply request handed from the frame checker to the reply sequencer
    typedef struct packed {
        frame_status_t status;
        logic [7:0]    id;
        logic [7:0]    func;
        logic [15:0]   addr;
        logic [15:0]   value;
    } reply_req_t;

    // One byte through the reflected CRC-16, bit by bit
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data_in);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data_in};
        for (int i = 0; i < 8; i++)
        begin
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

endpackage

FILE: rtl/core/mbrtu_reply.sv
// ============================================================================
// mbrtu_reply - reply sequencer
// Holds one frame outcome and streams it out: eight reply bytes with a CRC
// built on the fly, or a single status transaction for a rejected frame.
// ============================================================================
module mbrtu_reply (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  mbrtu_pkg::reply_req_t req,
    output logic                  free,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [7:0] tx_byte
    output logic [2:0]            m_axis_tuser,   // [0] tx_valid, [2:1] frame_status
    output logic                  m_axis_tlast
);

    logic                     busy_reg, busy_next;
    logic [2:0]               idx_reg, idx_next;
    logic                     single_reg;
    mbrtu_pkg::frame_status_t status_reg;
    logic [7:0]               id_reg;
    logic [7:0]               func_reg;
    logic [15:0]              addr_reg;
    logic [15:0]              value_reg;
    logic [15:0]              crc_reg, crc_next;
    logic [7:0]               byte_sel;
    logic                     out_take;

    // Current reply byte
    always_comb
    begin
        unique case (idx_reg)
            mbrtu_pkg::BYTE_ID:      byte_sel = id_reg;
            mbrtu_pkg::BYTE_FUNC:    byte_sel = func_reg;
            mbrtu_pkg::BYTE_ADDR_HI: byte_sel = addr_reg[15:8];
            mbrtu_pkg::BYTE_ADDR_LO: byte_sel = addr_reg[7:0];
            mbrtu_pkg::BYTE_VAL_HI:  byte_sel = value_reg[15:8];
            mbrtu_pkg::BYTE_VAL_LO:  byte_sel = value_reg[7:0];
            mbrtu_pkg::BYTE_CRC_HI:  byte_sel = crc_reg[15:8];
            mbrtu_pkg::BYTE_CRC_LO:  byte_sel = crc_reg[7:0];
            default:                 byte_sel = 8'h00;
        endcase
    end

    // Output channel
    assign m_axis_tvalid = busy_reg;
    assign m_axis_tdata  = single_reg ? 8'h00 : byte_sel;
    assign m_axis_tuser  = {status_reg, ~single_reg};
    assign m_axis_tlast  = single_reg || (idx_reg == mbrtu_pkg::BYTE_CRC_LO);
    assign out_take      = busy_reg && m_axis_tready;
    assign free          = !busy_reg || (out_take && m_axis_tlast);

    // Sequencer control
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        crc_next  = crc_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = mbrtu_pkg::BYTE_ID;
            crc_next  = mbrtu_pkg::CRC_INIT;
        end
        else if (out_take)
        begin
            if (m_axis_tlast)
            begin
                busy_next = 1'b0;
            end
            idx_next = idx_reg + 3'd1;
            // CRC runs over id to value low byte as they leave
            if (idx_reg <= mbrtu_pkg::BYTE_VAL_LO)
            begin
                crc_next = mbrtu_pkg::crc16_byte(crc_reg, byte_sel);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= mbrtu_pkg::BYTE_ID;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // Payload of the held reply
    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        if (load)
        begin
            single_reg <= (req.status != mbrtu_pkg::ST_OK);
            status_reg <= req.status;
            id_reg     <= req.id;
            func_reg   <= req.func;
            addr_reg   <= req.addr;
            value_reg  <= req.value;
        end
    end

`ifndef SYNTHESIS
    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> busy_reg && (idx_reg == mbrtu_pkg::BYTE_ID))
        else $error("reply load did not start at the first byte");

    a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && single_reg |-> (idx_reg == mbrtu_pkg::BYTE_ID))
        else $error("status transaction advanced past its single item");

    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && m_axis_tlast && !load |=> !busy_reg)
        else $error("sequencer still busy after final transaction");
`endif

endmodule

FILE: rtl/core/modbus_rtu_slave_frame_handler_top.sv
// ============================================================================
// modbus_rtu_slave_frame_handler_top - Modbus RTU slave frame handler
// Collects 8-byte request frames, checks CRC, node id and length, answers
// reads of one register with a CRC-protected reply, others with an exception.
// ============================================================================
// Usage:
//   s_axis carries received bytes (tuser low) or an inter-frame gap marker
//   (tuser high, ends a short frame). reading_value rides along in tdata and
//   is sampled from the transaction that completes a frame.
//   m_axis gives either eight reply bytes (tuser[0] high, status OK, tlast on
//   the CRC low byte) or one status transaction for a rejected frame.
//   node_id and register_address are set over the APB port (0x0, 0x4).
// Timing:
//   One input transaction per cycle unless a completing item waits. An item
//   is registered on acceptance and processed from the input register; a
//   completing byte loads the reply sequencer, whose registered output then
//   presents the reply, one byte per cycle while m_axis_tready is high.
//   A frame-completing item waits in the input register only while the
//   previous reply is still in flight (its last byte may leave the same
//   cycle); other items never wait on the output side.
// Reset:
//   Clears the frame under construction, drops any pending reply and
//   restores node_id to 2 and register_address to 6.
// Stall:
//   When m_axis_tready is low the current reply transaction holds.
// ============================================================================
module modbus_rtu_slave_frame_handler_top (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Receive stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] rx_byte, [23:8] reading_value
    input  logic        s_axis_tuser,   // [0] action
    // Reply stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] tx_byte
    output logic [2:0]  m_axis_tuser,   // [0] tx_valid, [2:1] frame_status
    output logic        m_axis_tlast
);

    logic [7:0]            node_id_q;
    logic [15:0]           reg_addr_q;
    logic                  cfg_wr;

    logic                  in_valid_reg, in_valid_next;
    logic                  in_action_reg;
    logic [7:0]            in_byte_reg;
    logic [15:0]           in_reading_reg;
    logic                  in_accept;

    logic [2:0]            byte_cnt_reg, byte_cnt_next;
    logic [15:0]           crc_reg, crc_next;
    logic [7:0]            id_reg, id_next;
    logic [7:0]            func_reg, func_next;
    logic [7:0]            addr_hi_reg, addr_hi_next;
    logic [7:0]            addr_lo_reg, addr_lo_next;
    logic [7:0]            b6_reg, b6_next;

    logic                  proc_finish;
    logic                  proc_done;
    logic                  rep_free;
    logic                  rep_load;
    logic [15:0]           got_crc;
    logic [15:0]           req_addr;
    mbrtu_pkg::reply_req_t rep_req;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_q  <= mbrtu_pkg::NODE_ID_RST;
            reg_addr_q <= mbrtu_pkg::REG_ADDR_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                mbrtu_pkg::CFG_IDX_NODE_ID:  node_id_q  <= pwdata[7:0];
                mbrtu_pkg::CFG_IDX_REG_ADDR: reg_addr_q <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            mbrtu_pkg::CFG_IDX_NODE_ID:  prdata = {24'h000000, node_id_q};
            mbrtu_pkg::CFG_IDX_REG_ADDR: prdata = {16'h0000, reg_addr_q};
            default:                     prdata = 32'h00000000;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    assign s_axis_tready = !in_valid_reg || proc_done;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc_done)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_action_reg  <= s_axis_tuser;
            in_byte_reg    <= s_axis_tdata[7:0];
            in_reading_reg <= s_axis_tdata[23:8];
        end
    end

    // ------------------------------------------------------------------
    // Frame completion: eighth byte, or a gap after at least one byte
    // ------------------------------------------------------------------
    assign proc_finish = in_valid_reg &&
                         (in_action_reg ? (byte_cnt_reg != 3'd0)
                                        : (byte_cnt_reg == mbrtu_pkg::BYTE_CRC_LO));
    assign proc_done   = in_valid_reg && (!proc_finish || rep_free);
    assign rep_load    = proc_done && proc_finish;

    // Frame assembly and running CRC
    always_comb
    begin
        byte_cnt_next = byte_cnt_reg;
        crc_next      = crc_reg;
        id_next       = id_reg;
        func_next     = func_reg;
        addr_hi_next  = addr_hi_reg;
        addr_lo_next  = addr_lo_reg;
        b6_next       = b6_reg;
        if (rep_load)
        begin
            byte_cnt_next = 3'd0;
            crc_next      = mbrtu_pkg::CRC_INIT;
            id_next       = 8'h00;
            func_next     = 8'h00;
            addr_hi_next  = 8'h00;
            addr_lo_next  = 8'h00;
            b6_next       = 8'h00;
        end
        else if (proc_done && !in_action_reg)
        begin
            unique case (byte_cnt_reg)
                mbrtu_pkg::BYTE_ID:      id_next      = in_byte_reg;
                mbrtu_pkg::BYTE_FUNC:    func_next    = in_byte_reg;
                mbrtu_pkg::BYTE_ADDR_HI: addr_hi_next = in_byte_reg;
                mbrtu_pkg::BYTE_ADDR_LO: addr_lo_next = in_byte_reg;
                mbrtu_pkg::BYTE_CRC_HI:  b6_next      = in_byte_reg;
                default: ;
            endcase
            if (byte_cnt_reg <= mbrtu_pkg::BYTE_VAL_LO)
            begin
                crc_next = mbrtu_pkg::crc16_byte(crc_reg, in_byte_reg);
            end
            byte_cnt_next = byte_cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg <= 3'd0;
            crc_reg      <= mbrtu_pkg::CRC_INIT;
            id_reg       <= 8'h00;
            func_reg     <= 8'h00;
            addr_hi_reg  <= 8'h00;
            addr_lo_reg  <= 8'h00;
            b6_reg       <= 8'h00;
        end
        else
        begin
            byte_cnt_reg <= byte_cnt_next;
            crc_reg      <= crc_next;
            id_reg       <= id_next;
            func_reg     <= func_next;
            addr_hi_reg  <= addr_hi_next;
            addr_lo_reg  <= addr_lo_next;
            b6_reg       <= b6_next;
        end
    end

    // ------------------------------------------------------------------
    // Frame check and reply contents
    // Padding a short frame with zero bytes is a linear, invertible map of
    // the CRC, and the received CRC field of such a frame reads zero below
    // byte 7, so comparing the unpadded running CRC is equivalent.
    // ------------------------------------------------------------------
    assign got_crc  = {b6_reg, (in_action_reg ? 8'h00 : in_byte_reg)};
    assign req_addr = {addr_hi_reg, addr_lo_reg};

    always_comb
    begin
        rep_req.id    = id_reg;
        rep_req.addr  = req_addr;
        rep_req.func  = func_reg | mbrtu_pkg::EXC_FLAG;
        rep_req.value = mbrtu_pkg::EXC_ADDR;

        priority if (crc_reg != got_crc)
        begin
            rep_req.status = mbrtu_pkg::ST_CRC;
        end
        else if (id_reg != node_id_q)
        begin
            rep_req.status = mbrtu_pkg::ST_ADDR;
        end
        else if (in_action_reg)
        begin
            rep_req.status = mbrtu_pkg::ST_SHORT;
        end
        else
        begin
            rep_req.status = mbrtu_pkg::ST_OK;
        end

        if (req_addr == reg_addr_q)
        begin
            if (func_reg == mbrtu_pkg::FUNC_READ)
            begin
                rep_req.func  = func_reg;
                rep_req.value = in_reading_reg;
            end
            else
            begin
                rep_req.value = mbrtu_pkg::EXC_FUNC;
            end
        end
    end

    // ------------------------------------------------------------------
    // Reply sequencer
    // ------------------------------------------------------------------
    mbrtu_reply u_reply (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (rep_load),
        .req           (rep_req),
        .free          (rep_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        rep_load |=> (byte_cnt_reg == 3'd0) && (crc_reg == mbrtu_pkg::CRC_INIT))
        else $error("frame state not cleared after completion");

    a_held_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !proc_done |=> in_valid_reg && $stable(in_byte_reg))
        else $error("waiting input item was lost");

    a_empty_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && in_action_reg && (byte_cnt_reg == 3'd0) |-> !rep_load)
        else $error("gap with no bytes produced a result");
`endif

endmodule
